// ----- design/dft_pkg.sv -----
// ----------------------------------------------------------------------------
// dft_pkg
// Types and constants shared by the forward frame transmitter and its checker.
// ----------------------------------------------------------------------------
package dft_pkg;

  localparam int unsigned FrameW   = 17;
  localparam int unsigned FrameTop = FrameW - 1;
  localparam int unsigned BitIdxW  = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [ByteW-1:0] StopGapReset   = 8'd34;
  localparam logic             InvertPinReset = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_GAP  = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STOP_GAP   = 1'b0,
    CFG_INVERT_PIN = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_SEND = 1'b1
  } kind_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] address_byte;
    logic [ByteW-1:0] data_byte;
    logic             send_twice;
  } dft_in_t;

  typedef struct packed {
    logic bus_level;
    logic pin_level;
    logic busy_res;
    logic accepted;
  } dft_out_t;

endpackage

// ----- design/dali_forward_frame_transmitter.sv -----
// ----------------------------------------------------------------------------
// dali_forward_frame_transmitter
// Manchester forward frame transmitter driven by half-bit ticks.
// ----------------------------------------------------------------------------
// Takes one item (a half-bit tick or a send request) per clock when not stalled
// and returns one result per item, registered, in the cycle after the transfer.
// The whole state update is a single pass of logic into the result register;
// the input stalls only while a stalled output holds a finished result. A send
// request is taken only when idle; the 17-bit frame (start bit, address, data)
// goes out MSB first, one half-bit per tick, optionally twice with an idle gap
// after each copy. Register 0 sets the gap in ticks, register 1 inverts the pin.
module dali_forward_frame_transmitter
  import dft_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dft_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dft_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  logic [ByteW-1:0]   stop_gap_q;
  logic               invert_pin_q;

  phase_e             phase_q, phase_d;
  logic [FrameW-1:0]  frame_q, frame_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic               first_half_q, first_half_d;
  logic               copies_left_q, copies_left_d;
  logic [ByteW-1:0]   gap_cnt_q, gap_cnt_d;
  logic               line_q, line_d;
  logic               repeat_q, repeat_d;

  logic               out_valid_q;
  dft_out_t           out_q, out_d;
  logic               in_xfer;
  logic               busy_now;
  logic               acc;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_gap_q   <= StopGapReset;
      invert_pin_q <= InvertPinReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_STOP_GAP:   stop_gap_q   <= cfg_data_i;
        CFG_INVERT_PIN: invert_pin_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d       = phase_q;
    frame_d       = frame_q;
    bit_idx_d     = bit_idx_q;
    first_half_d  = first_half_q;
    copies_left_d = copies_left_q;
    gap_cnt_d     = gap_cnt_q;
    line_d        = line_q;
    repeat_d      = repeat_q;
    acc           = 1'b0;
    busy_now      = (phase_q == PH_SEND) || (phase_q == PH_GAP);

    if (in_data_i.kind == KIND_SEND) begin
      if (!busy_now) begin
        frame_d       = {1'b1, in_data_i.address_byte, in_data_i.data_byte};
        repeat_d      = in_data_i.send_twice;
        copies_left_d = in_data_i.send_twice;
        bit_idx_d     = BitIdxW'(FrameTop);
        first_half_d  = 1'b1;
        phase_d       = PH_SEND;
        line_d        = 1'b0;
        acc           = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_SEND: begin
          if (first_half_q) begin
            line_d       = frame_q[bit_idx_q];
            first_half_d = 1'b0;
          end else if (bit_idx_q == '0) begin
            line_d = 1'b1;
            if (repeat_q) begin
              phase_d   = PH_GAP;
              gap_cnt_d = stop_gap_q;
            end else begin
              phase_d = PH_IDLE;
            end
          end else begin
            bit_idx_d    = bit_idx_q - 1'b1;
            first_half_d = 1'b1;
            line_d       = ~frame_q[bit_idx_q - 1'b1];
          end
        end
        PH_GAP: begin
          if (gap_cnt_q != '0) begin
            gap_cnt_d = gap_cnt_q - 1'b1;
          end else if (copies_left_q) begin
            copies_left_d = 1'b0;
            bit_idx_d     = BitIdxW'(FrameTop);
            first_half_d  = 1'b1;
            phase_d       = PH_SEND;
            line_d        = 1'b0;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end

    out_d.bus_level = line_d;
    out_d.pin_level = line_d ^ invert_pin_q;
    out_d.busy_res  = (phase_d == PH_SEND) || (phase_d == PH_GAP);
    out_d.accepted  = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      frame_q       <= '0;
      bit_idx_q     <= '0;
      first_half_q  <= 1'b1;
      copies_left_q <= 1'b0;
      gap_cnt_q     <= '0;
      line_q        <= 1'b1;
      repeat_q      <= 1'b0;
    end else if (in_xfer) begin
      phase_q       <= phase_d;
      frame_q       <= frame_d;
      bit_idx_q     <= bit_idx_d;
      first_half_q  <= first_half_d;
      copies_left_q <= copies_left_d;
      gap_cnt_q     <= gap_cnt_d;
      line_q        <= line_d;
      repeat_q      <= repeat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- design/dft_checker.sv -----
// ----------------------------------------------------------------------------
// dft_checker
// Port-level checks for the forward frame transmitter, bound to that module.
// ----------------------------------------------------------------------------
module dft_checker
  import dft_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input dft_out_t out_data_o
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.busy_res &&
      !out_data_o.bus_level)
    else $error("accepted send did not start a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |-> out_data_o.bus_level)
    else $error("bus not idle high while not busy");

endmodule

bind dali_forward_frame_transmitter dft_checker u_dft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the forward frame transmitter against a cycle-free line predictor.
// ----------------------------------------------------------------------------
// Every input transfer (half-bit tick or send request) is run through a local
// copy of the transmitter state, and the bus, pin, busy and accept flags it
// should give are queued. Each output transfer is checked against the oldest
// queued entry. Directed frames cover the reset settings, a refused request,
// no gap and a long gap; random traffic then sends frames with random
// bytes and repeat flags under several gap and polarity settings, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import dft_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned RandomItems   = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  dft_in_t            in_data;
  logic               out_valid;
  logic               out_stall;
  dft_out_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;

  dali_forward_frame_transmitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // line predictor state
  phase_e             tx_phase;
  logic [FrameW-1:0]  tx_frame;
  logic [BitIdxW-1:0] tx_bit;
  logic               tx_first_half;
  logic               tx_copy_left;
  logic [ByteW-1:0]   tx_gap_left;
  logic               tx_line;
  logic               tx_repeat;
  logic [ByteW-1:0]   stop_gap_cfg;
  logic               invert_cfg;

  dft_out_t pending_levels[$];
  int       errors;
  logic     calm;
  int       stall_left;
  int       quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic void start_copy();
    tx_bit        = BitIdxW'(FrameTop);
    tx_first_half = 1'b1;
    tx_phase      = PH_SEND;
    tx_line       = 1'b0;
  endfunction

  function automatic logic tx_busy();
    return (tx_phase == PH_SEND) || (tx_phase == PH_GAP);
  endfunction

  function automatic dft_out_t predict_line(input dft_in_t item);
    dft_out_t r;
    logic     taken;
    taken = 1'b0;
    if (item.kind == KIND_SEND) begin
      if (!tx_busy()) begin
        tx_frame     = {1'b1, item.address_byte, item.data_byte};
        tx_repeat    = item.send_twice;
        tx_copy_left = item.send_twice;
        start_copy();
        taken = 1'b1;
      end
    end else if (tx_phase == PH_SEND) begin
      if (tx_first_half) begin
        tx_line       = tx_frame[tx_bit];
        tx_first_half = 1'b0;
      end else if (tx_bit == '0) begin
        tx_line = 1'b1;
        if (tx_repeat) begin
          tx_phase    = PH_GAP;
          tx_gap_left = stop_gap_cfg;
        end else begin
          tx_phase = PH_IDLE;
        end
      end else begin
        tx_bit        = tx_bit - 1'b1;
        tx_first_half = 1'b1;
        tx_line       = ~tx_frame[tx_bit];
      end
    end else if (tx_phase == PH_GAP) begin
      if (tx_gap_left != '0) begin
        tx_gap_left = tx_gap_left - 1'b1;
      end else if (tx_copy_left) begin
        tx_copy_left = 1'b0;
        start_copy();
      end else begin
        tx_phase = PH_IDLE;
      end
    end
    r.bus_level = tx_line;
    r.pin_level = tx_line ^ invert_cfg;
    r.busy_res  = tx_busy();
    r.accepted  = taken;
    return r;
  endfunction

  function automatic dft_in_t make_item(input kind_e kind);
    dft_in_t item;
    item.kind         = kind;
    item.address_byte = ByteW'($urandom);
    item.data_byte    = ByteW'($urandom);
    item.send_twice   = 1'($urandom);
    return item;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // valid is left high after the transfer; drain_line lowers it, as does the next call when it inserts a gap
  task automatic send_item(input dft_in_t item);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    pending_levels.push_back(predict_line(item));
  endtask

  task automatic send_tick();
    send_item(make_item(KIND_TICK));
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] data, input logic twice);
    dft_in_t item;
    item.kind         = KIND_SEND;
    item.address_byte = addr;
    item.data_byte    = data;
    item.send_twice   = twice;
    send_item(item);
  endtask

  task automatic tick_until_idle();
    while (tx_busy()) send_tick();
  endtask

  task automatic drain_line();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ByteW-1:0] gap, input logic inv);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STOP_GAP;
    cfg_data  <= gap;
    do @(posedge clk_i); while (!cfg_ready);
    stop_gap_cfg = gap;
    cfg_index <= CFG_INVERT_PIN;
    cfg_data  <= {{(ByteW-1){1'b0}}, inv};
    do @(posedge clk_i); while (!cfg_ready);
    invert_cfg = inv;
    cfg_valid <= 1'b0;
  endtask

  // reset settings: idle ticks, a plain frame, a refused request mid-frame
  task automatic test_reset_settings();
    send_tick();
    send_tick();
    send_frame(8'hFF, 8'h00, 1'b0);
    send_tick();
    send_frame(8'h12, 8'h34, 1'b1);
    tick_until_idle();
    send_tick();
  endtask

  task automatic test_repeat_no_gap();
    drain_line();
    set_config(8'd0, 1'b0);
    send_frame(8'h00, 8'hFF, 1'b1);
    repeat (33) send_tick();
    send_frame(8'hAA, 8'h55, 1'b0);
    tick_until_idle();
    send_tick();
  endtask

  // gap with the top bit of the count set
  task automatic test_long_gap();
    drain_line();
    set_config(8'd130, 1'b1);
    send_frame(8'hA5, 8'h5A, 1'b1);
    repeat (40) send_tick();
    send_frame(8'h0F, 8'hF0, 1'b0);
    tick_until_idle();
    send_tick();
  endtask

  task automatic test_random_traffic();
    int      counted;
    int      since_cfg;
    logic    busy;
    dft_in_t item;
    counted   = 0;
    since_cfg = 0;
    while (counted < RandomItems) begin
      busy = tx_busy();
      if (!busy && since_cfg >= 20) begin
        drain_line();
        set_config(($urandom_range(0, 3) == 0) ? 8'd0 : ByteW'($urandom_range(1, 12)),
                   1'($urandom));
        calm      = ($urandom_range(0, 3) == 0);
        since_cfg = 0;
      end
      if (busy) begin
        item = make_item(($urandom_range(0, 99) < 94) ? KIND_TICK : KIND_SEND);
      end else begin
        item = make_item(($urandom_range(0, 99) < 85) ? KIND_SEND : KIND_TICK);
      end
      if ((item.kind == KIND_TICK) == busy) begin
        counted++;
        since_cfg++;
      end
      send_item(item);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    dft_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("result transfer with no result expected");
      end else begin
        want = pending_levels.pop_front();
        if (out_data.bus_level !== want.bus_level)
          report_mismatch($sformatf("bus_level %b, expected %b",
                                    out_data.bus_level, want.bus_level));
        if (out_data.pin_level !== want.pin_level)
          report_mismatch($sformatf("pin_level %b, expected %b",
                                    out_data.pin_level, want.pin_level));
        if (out_data.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, expected %b",
                                    out_data.busy_res, want.busy_res));
        if (out_data.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %b, expected %b",
                                    out_data.accepted, want.accepted));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_STOP_GAP;
    cfg_data      = '0;
    errors        = 0;
    calm          = 1'b0;
    stall_left    = 0;
    quiet_cycles  = 0;
    stop_gap_cfg  = StopGapReset;
    invert_cfg    = InvertPinReset;
    tx_phase      = PH_IDLE;
    tx_frame      = '0;
    tx_bit        = '0;
    tx_first_half = 1'b1;
    tx_copy_left  = 1'b0;
    tx_gap_left   = '0;
    tx_line       = 1'b1;
    tx_repeat     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_repeat_no_gap();
    test_long_gap();
    test_random_traffic();
    drain_line();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
